FILE: rtl/core/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the chunk reassembly tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int DEPTH        = 2048;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ADDR_W       = $clog2(DEPTH);
    // Epoch tag kept beside each stored sample; tag 0 means not written since the last sweep.
    localparam int EPOCH_W      = 6;
    localparam int RAM_W        = SAMPLE_WIDTH + EPOCH_W;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_FINAL = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_INDEX     = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_WRITE,
        OP_FINAL,
        OP_READ,
        OP_CLEAR,
        OP_BAD
    } op_kind_t;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_LOOKUP
    } back_state_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        op_kind_t     kind;
        status_t      chk;      // begin argument check
        logic         idx_bad;  // index beyond the store
        logic [11:0]  count;
        logic         fmt;
        logic [10:0]  index;
        logic [15:0]  sample;
    } op_t;

    typedef struct packed {
        status_t      status;
        logic [15:0]  read_sample;
        logic         ready_flag;
        logic [11:0]  final_length;
        logic [11:0]  expected_total;
        logic         format_out;
        logic [31:0]  generation_out;
        logic [11:0]  filled_count;
        logic         invalidate_pulse;
    } result_t;

endpackage

FILE: rtl/core/chunk_reassembly_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker
// Sample store with written marks that rebuilds a waveform from chunks.
// ----------------------------------------------------------------------------
// Commands arrive on s_ and every item gives exactly one result on m_. A
// front stage decodes each item and checks begin arguments into a two-entry
// queue, so the input keeps flowing while the execution side is busy or m_
// is stalled. In the execution side, begin, clear, finalize, unknown codes
// and a rejected write finish from the idle state; an accepted write and a
// read first pass the lookup state, because the store is one RAM with
// registered read and a write must first look up whether its position was
// already written. Written marks are an epoch tag stored beside each sample,
// so a clear does not touch the RAM. The tag space is refreshed by a sweep
// over all DEPTH (2048) entries, one entry per cycle, right after reset and
// after every 63rd clear or accepted begin; during a sweep up to two items
// are still taken into the queue, then s_tready drops, and none is executed
// until the sweep ends. A read of a position not written since the last
// clear answers zero. chunk_end (s_tlast) is informational and has no effect.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // count[11:0], format_sel[13:12], index[24:14], sample[40:25], zero pad
    input  logic [crt_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[2:0]
    input  logic [crt_pkg::S_TUSER_W-1:0] s_tuser,
    // chunk_end, ignored
    input  logic                          s_tlast,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_sample[15:0], ready_flag[16], final_length[28:17],
    // expected_total[40:29], format_out[41], generation_out[73:42],
    // filled_count[85:74], invalidate_pulse[86], zero pad
    output logic [crt_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [crt_pkg::M_TUSER_W-1:0] m_tuser
);
    import crt_pkg::*;

    logic    q_full, q_push, q_pop, q_valid;
    op_t     q_in, q_head;
    result_t res;

    crt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in)
    );

    crt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head)
    );

    crt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_op    (q_head),
        .pop        (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {1'b0, res.invalidate_pulse, res.filled_count, res.generation_out,
                      res.format_out, res.expected_total, res.final_length,
                      res.ready_flag, res.read_sample};

    // Ready always comes with the finalized length equal to the expected total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.ready_flag) |-> (res.final_length == res.expected_total))
        else $error("ready set with final length differing from expected total");

    // Never more distinct positions than expected.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.filled_count <= res.expected_total))
        else $error("filled count exceeds expected total");

    // An invalidating item leaves an empty store, ok status, nonzero generation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.invalidate_pulse) |->
            (res.filled_count == 12'd0 && res.status == ST_OK &&
             res.generation_out != 32'd0 && !res.ready_flag))
        else $error("invalidate result with stale state");

    // Queue pop only when something is queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

FILE: rtl/core/crt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/crt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_front
// Input side: takes items, decodes the command and checks begin arguments.
// ----------------------------------------------------------------------------
module crt_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [crt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [crt_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output crt_pkg::op_t                   q_op
);
    import crt_pkg::*;

    logic [11:0] count;
    logic [1:0]  fmt_sel;

    assign count   = s_tdata[11:0];
    assign fmt_sel = s_tdata[13:12];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_op         = '0;
        q_op.count   = count;
        q_op.fmt     = fmt_sel[0];
        q_op.index   = s_tdata[24:14];
        q_op.sample  = s_tdata[40:25];
        q_op.idx_bad = (32'(s_tdata[24:14]) >= 32'(DEPTH));

        if (count == 12'd0) begin
            q_op.chk = ST_EMPTY;
        end else if (32'(count) > 32'(DEPTH)) begin
            q_op.chk = ST_TOO_LARGE;
        end else if (fmt_sel > 2'd1) begin
            q_op.chk = ST_INDEX;
        end else begin
            q_op.chk = ST_OK;
        end

        case (s_tuser)
            CMD_BEGIN: q_op.kind = OP_BEGIN;
            CMD_WRITE: q_op.kind = OP_WRITE;
            CMD_FINAL: q_op.kind = OP_FINAL;
            CMD_READ:  q_op.kind = OP_READ;
            CMD_CLEAR: q_op.kind = OP_CLEAR;
            default:   q_op.kind = OP_BAD;
        endcase
    end

endmodule

FILE: rtl/core/crt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_queue
// Two-entry queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module crt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  crt_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output crt_pkg::op_t  head_op
);
    import crt_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/core/crt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_back
// Execution side: sample store with epoch-tagged written marks, counters,
// generation, and the result register.
// ----------------------------------------------------------------------------
module crt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  crt_pkg::op_t     head_op,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output crt_pkg::result_t res
);
    import crt_pkg::*;

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    op_t                cur_reg, cur_next;
    logic [11:0]        filled_reg, filled_next;
    logic [11:0]        expected_reg, expected_next;
    logic [11:0]        vlen_reg, vlen_next;
    logic               ready_reg, ready_next;
    logic               fmt_reg, fmt_next;
    logic [31:0]        gen_reg, gen_next, gen_inc;
    logic               valid_reg, valid_next;
    result_t            res_reg, res_next;

    logic               out_free, done, do_clear, do_begin, hit;
    status_t            status;
    logic [15:0]        rd_val;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [RAM_W-1:0]   ram_wdata, ram_rdata;

    crt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !valid_reg || res_ready;
    assign hit      = (ram_rdata[SAMPLE_WIDTH +: EPOCH_W] == epoch_reg);
    assign gen_inc  = gen_reg + 32'd1;

    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        epoch_next    = epoch_reg;
        cur_next      = cur_reg;
        filled_next   = filled_reg;
        expected_next = expected_reg;
        vlen_next     = vlen_reg;
        ready_next    = ready_reg;
        fmt_next      = fmt_reg;
        gen_next      = gen_reg;
        pop           = 1'b0;
        done          = 1'b0;
        do_clear      = 1'b0;
        do_begin      = 1'b0;
        status        = ST_OK;
        rd_val        = 16'd0;
        ram_we        = 1'b0;
        ram_waddr     = sweep_reg;
        ram_wdata     = '0;
        ram_raddr     = ADDR_W'(cur_reg.index);

        case (state_reg)
            B_SWEEP: begin
                // Tag 0 on every entry: nothing reads as written.
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                ram_raddr = ADDR_W'(head_op.index);
                if (head_valid && out_free) begin
                    pop      = 1'b1;
                    cur_next = head_op;
                    case (head_op.kind)
                        OP_BEGIN: begin
                            done   = 1'b1;
                            status = head_op.chk;
                            if (head_op.chk == ST_OK) begin
                                do_clear = 1'b1;
                                do_begin = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            done     = 1'b1;
                            do_clear = 1'b1;
                        end
                        OP_WRITE: begin
                            if (expected_reg == 12'd0) begin
                                done   = 1'b1;
                                status = ST_EMPTY;
                            end else if ({1'b0, head_op.index} >= expected_reg) begin
                                done   = 1'b1;
                                status = ST_INDEX;
                            end else begin
                                state_next = B_LOOKUP;
                            end
                        end
                        OP_FINAL: begin
                            done = 1'b1;
                            if (expected_reg == 12'd0) begin
                                status = ST_EMPTY;
                            end else if (filled_reg != expected_reg) begin
                                status = ST_INDEX;
                            end else begin
                                vlen_next  = expected_reg;
                                ready_next = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (head_op.idx_bad) begin
                                done   = 1'b1;
                                status = ST_INDEX;
                            end else begin
                                state_next = B_LOOKUP;
                            end
                        end
                        default: begin
                            done   = 1'b1;
                            status = ST_INDEX;
                        end
                    endcase
                end
            end
            B_LOOKUP: begin
                // Read data for cur_reg.index is held while the output stalls.
                if (out_free) begin
                    done       = 1'b1;
                    state_next = B_IDLE;
                    if (cur_reg.kind == OP_WRITE) begin
                        ram_we     = 1'b1;
                        ram_waddr  = ADDR_W'(cur_reg.index);
                        ram_wdata  = {epoch_reg, SAMPLE_WIDTH'($signed(cur_reg.sample))};
                        ready_next = 1'b0;
                        vlen_next  = 12'd0;
                        if (!hit) begin
                            filled_next = filled_reg + 12'd1;
                        end
                    end else if (hit) begin
                        rd_val = 16'($signed(ram_rdata[SAMPLE_WIDTH-1:0]));
                    end
                end
            end
            default: begin
                state_next = B_SWEEP;
            end
        endcase

        if (do_clear) begin
            gen_next      = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
            filled_next   = 12'd0;
            expected_next = 12'd0;
            vlen_next     = 12'd0;
            ready_next    = 1'b0;
            fmt_next      = 1'b0;
            // Tag space used up: restart at 1 behind a full sweep.
            if (epoch_reg == {EPOCH_W{1'b1}}) begin
                epoch_next = EPOCH_W'(1);
                state_next = B_SWEEP;
            end else begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
        if (do_begin) begin
            expected_next = head_op.count;
            fmt_next      = head_op.fmt;
        end

        res_next                  = res_reg;
        res_next.status           = status;
        res_next.read_sample      = rd_val;
        res_next.ready_flag       = ready_next;
        res_next.final_length     = vlen_next;
        res_next.expected_total   = expected_next;
        res_next.format_out       = fmt_next;
        res_next.generation_out   = gen_next;
        res_next.filled_count     = filled_next;
        res_next.invalidate_pulse = do_clear;

        valid_next = done ? 1'b1 : (res_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_SWEEP;
            sweep_reg    <= '0;
            epoch_reg    <= EPOCH_W'(1);
            filled_reg   <= 12'd0;
            expected_reg <= 12'd0;
            vlen_reg     <= 12'd0;
            ready_reg    <= 1'b0;
            fmt_reg      <= 1'b0;
            gen_reg      <= 32'd0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            epoch_reg    <= epoch_next;
            filled_reg   <= filled_next;
            expected_reg <= expected_next;
            vlen_reg     <= vlen_next;
            ready_reg    <= ready_next;
            fmt_reg      <= fmt_next;
            gen_reg      <= gen_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (done) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

FILE: bench/chunk_reassembly_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker_tb
// Self-checking bench for the chunk reassembly tracker. A scoreboard class
// keeps its own copy of the sample store, written marks and counters, works
// out the one result of every accepted item and compares each result item
// field by field. Stimulus is a directed opening, then begin/write/finalize
// sessions with random content mixed with random noise, under random idling
// on both sides.
// ----------------------------------------------------------------------------
import crt_pkg::*;

class crt_scoreboard;
    logic [15:0] store [DEPTH];
    bit          marked [DEPTH];      // written since last clear
    bit          touched [DEPTH];     // ever written since reset
    logic [10:0] touched_list [$];
    logic [11:0] filled;
    logic [11:0] expected;
    logic [11:0] vlen;
    bit          ready;
    bit          fmt;
    logic [31:0] gen;
    result_t     pending [$];
    int          errors;

    localparam logic [1:0] FMT_DAC = 2'd1;

    function new();
        foreach (marked[i]) begin
            marked[i]  = 1'b0;
            touched[i] = 1'b0;
            store[i]   = '0;
        end
        filled   = '0;
        expected = '0;
        vlen     = '0;
        ready    = 1'b0;
        fmt      = 1'b0;
        gen      = '0;
        errors   = 0;
    endfunction

    function bit has_stored();
        return touched_list.size() != 0;
    endfunction

    function logic [10:0] pick_stored();
        return touched_list[$urandom_range(0, touched_list.size() - 1)];
    endfunction

    function int outstanding();
        return pending.size();
    endfunction

    // Clear of marks and counters; generation skips zero on wrap.
    function void wipe();
        gen = gen + 32'd1;
        if (gen == '0)
            gen = 32'd1;
        foreach (marked[i])
            marked[i] = 1'b0;
        filled   = '0;
        expected = '0;
        vlen     = '0;
        ready    = 1'b0;
        fmt      = 1'b0;
    endfunction

    function void note_input(logic [2:0] cmd, logic [11:0] count, logic [1:0] fsel,
                             logic [10:0] idx, logic [15:0] smp);
        result_t r;
        status_t st;
        logic [15:0] rd;
        bit inval;
        st    = ST_OK;
        rd    = '0;
        inval = 1'b0;
        case (cmd)
            CMD_BEGIN: begin
                if (count == '0)
                    st = ST_EMPTY;
                else if (count > 12'(DEPTH))
                    st = ST_TOO_LARGE;
                else if (fsel > FMT_DAC)
                    st = ST_INDEX;
                else begin
                    wipe();
                    inval    = 1'b1;
                    expected = count;
                    fmt      = fsel[0];
                end
            end
            CMD_WRITE: begin
                if (expected == '0)
                    st = ST_EMPTY;
                else if ({1'b0, idx} >= expected)
                    st = ST_INDEX;
                else begin
                    store[idx] = smp;
                    if (!marked[idx]) begin
                        marked[idx] = 1'b1;
                        filled      = filled + 12'd1;
                    end
                    if (!touched[idx]) begin
                        touched[idx] = 1'b1;
                        touched_list.push_back(idx);
                    end
                    ready = 1'b0;
                    vlen  = '0;
                end
            end
            CMD_FINAL: begin
                if (expected == '0)
                    st = ST_EMPTY;
                else if (filled != expected)
                    st = ST_INDEX;
                else begin
                    vlen  = expected;
                    ready = 1'b1;
                end
            end
            CMD_READ: begin
                // an 11-bit index never leaves the store
                if (marked[idx])
                    rd = store[idx];
            end
            CMD_CLEAR: begin
                wipe();
                inval = 1'b1;
            end
            default: st = ST_INDEX;
        endcase
        r.status           = st;
        r.read_sample      = rd;
        r.ready_flag       = ready;
        r.final_length     = vlen;
        r.expected_total   = expected;
        r.format_out       = fmt;
        r.generation_out   = gen;
        r.filled_count     = filled;
        r.invalidate_pulse = inval;
        pending.push_back(r);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
        result_t want;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected result expected none actual tdata %h tuser %h",
                     $time, data, user);
            return;
        end
        want = pending.pop_front();
        match("status",           32'(want.status),           32'(user[1:0]));
        match("read_sample",      32'(want.read_sample),      32'(data[15:0]));
        match("ready_flag",       32'(want.ready_flag),       32'(data[16]));
        match("final_length",     32'(want.final_length),     32'(data[28:17]));
        match("expected_total",   32'(want.expected_total),   32'(data[40:29]));
        match("format_out",       32'(want.format_out),       32'(data[41]));
        match("generation_out",   want.generation_out,        data[73:42]);
        match("filled_count",     32'(want.filled_count),     32'(data[85:74]));
        match("invalidate_pulse", 32'(want.invalidate_pulse), 32'(data[86]));
    endfunction
endclass

module chunk_reassembly_tracker_tb;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int         TARGET_ITEMS = 1200;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    crt_scoreboard sb = new();
    int            items_sent = 0;
    bit            calm = 1'b0;     // no idling on either side while set

    chunk_reassembly_tracker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check accepted items, stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= aresetn && (calm || $urandom_range(0, 99) >= 9);
    end

    // One item on the input side; returns once it is accepted.
    task automatic put_item(input logic [2:0] cmd, input logic [11:0] count,
                            input logic [1:0] fsel, input logic [10:0] idx,
                            input logic [15:0] smp, input bit last);
        if (!calm && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, smp, idx, fsel, count};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(cmd, count, fsel, idx, smp);
        items_sent++;
        calm = (items_sent >= 300) && (items_sent < 550);
    endtask

    initial begin
        int          cnt;
        int          n;
        int          k;
        int          j;
        int          tmp;
        int          order [$];
        logic [2:0]  c;
        logic [11:0] cv;
        logic [10:0] ix;
        bit          drained;
        drained = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: commands with nothing begun, begin rejections,
        // full-size buffer with extreme samples, rewrite, finalize paths.
        put_item(CMD_WRITE, '0, '0, '0, 16'h1234, 1'b0);
        put_item(CMD_FINAL, '0, '0, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd0, 2'd0, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'hFFF, 2'd0, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd2049, 2'd1, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd5, 2'd2, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd5, 2'd3, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd2048, 2'd1, '0, '0, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd2047, 16'h7FFF, 1'b1);
        put_item(CMD_WRITE, '0, '0, 11'd0, 16'h8000, 1'b0);
        put_item(CMD_READ, '0, '0, 11'd2047, '0, 1'b0);
        put_item(CMD_READ, '0, '0, 11'd0, '0, 1'b0);
        put_item(CMD_FINAL, '0, '0, '0, '0, 1'b0);
        put_item(CMD_BEGIN, 12'd2, 2'd0, '0, '0, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd2, 16'h5555, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd0, 16'hFFFF, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd0, 16'h0001, 1'b0);
        put_item(CMD_FINAL, '0, '0, '0, '0, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd1, 16'h0000, 1'b1);
        put_item(CMD_FINAL, '0, '0, '0, '0, 1'b0);
        put_item(CMD_WRITE, '0, '0, 11'd1, 16'hAAAA, 1'b0);
        put_item(CMD_FINAL, '0, '0, '0, '0, 1'b0);
        put_item(CMD_READ, '0, '0, 11'd2047, '0, 1'b0);
        put_item(CMD_READ, '0, '0, 11'd1, '0, 1'b0);
        put_item(CMD_SPARE_LO, 12'hFFF, 2'd3, 11'h7FF, 16'hFFFF, 1'b1);
        put_item(CMD_SPARE_HI, '0, '0, '0, '0, 1'b0);
        put_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
        put_item(CMD_READ, '0, '0, 11'd0, '0, 1'b0);

        while (items_sent < TARGET_ITEMS) begin
            // hold off until every result is back, at least once
            if ((!drained && items_sent >= 600) || $urandom_range(0, 29) == 0) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.outstanding() != 0) @(posedge aclk);
                drained = 1'b1;
            end

            if ($urandom_range(0, 99) < 80) begin
                // well-formed session: begin, scattered writes, finalize
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(25, DEPTH)
                                                  : $urandom_range(1, 24);
                put_item(CMD_BEGIN, 12'(cnt), 2'($urandom_range(0, 1)), 11'($urandom),
                         16'($urandom), 1'($urandom));
                order.delete();
                if (cnt <= 24) begin
                    for (int i = 0; i < cnt; i++)
                        order.push_back(i);
                end else begin
                    n = $urandom_range(8, 30);
                    for (int i = 0; i < n; i++)
                        order.push_back($urandom_range(0, cnt - 1));
                    order.push_back(cnt - 1);
                end
                for (int i = order.size() - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                foreach (order[i]) begin
                    put_item(CMD_WRITE, 12'($urandom), 2'($urandom), 11'(order[i]),
                             16'($urandom),
                             (i == order.size() - 1) || ($urandom_range(0, 7) == 0));
                    k = $urandom_range(0, 99);
                    if (k < 8)
                        put_item(CMD_WRITE, 12'($urandom), 2'($urandom),
                                 11'(order[$urandom_range(0, i)]), 16'($urandom), 1'b0);
                    else if (k < 16 && sb.has_stored())
                        put_item(CMD_READ, 12'($urandom), 2'($urandom), sb.pick_stored(),
                                 16'($urandom), 1'($urandom));
                    else if (k < 20 && cnt < DEPTH)
                        put_item(CMD_WRITE, 12'($urandom), 2'($urandom),
                                 11'($urandom_range(cnt, DEPTH - 1)), 16'($urandom), 1'b0);
                    else if (k < 24)
                        put_item(CMD_FINAL, 12'($urandom), 2'($urandom), 11'($urandom),
                                 16'($urandom), 1'($urandom));
                end
                put_item(CMD_FINAL, 12'($urandom), 2'($urandom), 11'($urandom),
                         16'($urandom), 1'($urandom));
                k = $urandom_range(0, 99);
                if (k < 25) begin
                    put_item(CMD_READ, 12'($urandom), 2'($urandom), sb.pick_stored(),
                             16'($urandom), 1'($urandom));
                end else if (k < 45) begin
                    put_item(CMD_CLEAR, 12'($urandom), 2'($urandom), 11'($urandom),
                             16'($urandom), 1'($urandom));
                end else if (k < 55) begin
                    put_item(CMD_WRITE, 12'($urandom), 2'($urandom),
                             11'(order[$urandom_range(0, order.size() - 1)]),
                             16'($urandom), 1'b1);
                    put_item(CMD_FINAL, 12'($urandom), 2'($urandom), 11'($urandom),
                             16'($urandom), 1'($urandom));
                end
            end else begin
                // noise: any code, any field values
                n = $urandom_range(1, 8);
                repeat (n) begin
                    c = 3'($urandom_range(0, CMD_SPARE_HI));
                    if (c == CMD_READ && !sb.has_stored())
                        c = CMD_FINAL;
                    ix = (c == CMD_READ) ? sb.pick_stored() : 11'($urandom);
                    cv = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 30))
                                                     : 12'($urandom);
                    put_item(c, cv, 2'($urandom), ix, 16'($urandom), 1'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
